// ===== rtl/psk_pkg.sv =====
package psk_pkg;

    localparam int unsigned FULL_SCALE = 25600;
    localparam int unsigned KEY_W      = 15;
    localparam int unsigned NUM_W      = 26;
    localparam int unsigned DEN_W      = 11;

    localparam logic signed [15:0] EXCLUDED_KEY = -16'sd256;

    typedef enum logic [2:0] {
        MODE_HUE   = 3'd0,
        MODE_SAT   = 3'd1,
        MODE_LUM   = 3'd2,
        MODE_RED   = 3'd3,
        MODE_GREEN = 3'd4,
        MODE_BLUE  = 3'd5
    } t_key_mode;

    typedef enum logic [1:0] {
        REG_KEY_MODE  = 2'd0,
        REG_BAND_LOW  = 2'd1,
        REG_BAND_HIGH = 2'd2
    } t_reg_idx;

endpackage

// ===== rtl/pixel_sort_key_with_band_unit.sv =====
// Sort key unit for RGBA pixels with a threshold band.
// An item is a pixel on i_red, i_green, i_blue and i_alpha, taken at a rising
// edge where i_start is high and o_busy is low. o_busy is always low: the unit
// takes one item in every cycle.
// Each item gives one result on o_sort_key and o_excluded, shown for exactly
// one cycle with o_done high, after the input, divider and band stages.
// Results leave in the order their items came in.
// The key is turned into a numerator and a denominator in one stage, then a
// restoring divider unrolled into 15 register stages gives one quotient bit
// per stage, and a last stage applies the band. The divider sets the latency.
// Registers are written through i_cfg_we, i_cfg_idx and i_cfg_data, by the user
// only while no item is in flight; the unit does not enforce it. Index 0 is the
// key mode, 1 the band low, 2 the band high. Reset clears the pipeline valid bits
// and loads the register reset values; items in flight at reset are dropped.
// The receiver cannot stall, so no result is ever held back.
module pixel_sort_key_with_band_unit
    import psk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    input  logic [7:0]         i_alpha,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [14:0]        i_cfg_data,
    output logic               o_done,
    output logic signed [15:0] o_sort_key,
    output logic               o_excluded
);

    localparam int unsigned NSTG = KEY_W;

    logic [2:0]  r_mode;
    logic [14:0] r_lo;
    logic [14:0] r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HUE;
            r_lo   <= 15'd0;
            r_hi   <= 15'(FULL_SCALE);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY_MODE:  r_mode <= i_cfg_data[2:0];
                REG_BAND_LOW:  r_lo   <= i_cfg_data;
                REG_BAND_HIGH: r_hi   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic [7:0]  mx, mn, d;
    logic [8:0]  sum;
    logic [8:0]  sat_den;
    logic [10:0] hue_s;
    logic [NUM_W-1:0] n_num;
    logic [DEN_W-1:0] n_den;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        d   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        sat_den = (sum > 9'd255) ? (9'd510 - sum) : sum;
        if (i_red >= i_green && i_red >= i_blue) begin
            if (i_green >= i_blue) hue_s = {3'd0, i_green} - {3'd0, i_blue};
            else hue_s = {3'd0, i_green} - {3'd0, i_blue} + 11'd6 * {3'd0, d};
        end else if (i_green >= i_blue) begin
            hue_s = 11'd2 * {3'd0, d} + {3'd0, i_blue} - {3'd0, i_red};
        end else begin
            hue_s = 11'd4 * {3'd0, d} + {3'd0, i_red} - {3'd0, i_green};
        end
        case (r_mode)
            MODE_HUE: begin
                if (d == 8'd0) begin
                    n_num = '0;
                    n_den = 11'd1;
                end else begin
                    n_den = 11'd6 * {3'd0, d};
                    n_num = 26'd25600 * {15'd0, hue_s} + 26'd3 * {18'd0, d};
                end
            end
            MODE_SAT: begin
                if (d == 8'd0) begin
                    n_num = '0;
                    n_den = 11'd1;
                end else begin
                    n_den = {1'b0, sat_den, 1'b0};
                    n_num = 26'd51200 * {18'd0, d} + {17'd0, sat_den};
                end
            end
            MODE_LUM: begin
                n_den = 11'd102;
                n_num = 26'd5120 * {17'd0, sum} + 26'd51;
            end
            MODE_RED: begin
                n_den = 11'd102;
                n_num = 26'd10240 * {18'd0, i_red} + 26'd51;
            end
            MODE_GREEN: begin
                n_den = 11'd102;
                n_num = 26'd10240 * {18'd0, i_green} + 26'd51;
            end
            MODE_BLUE: begin
                n_den = 11'd102;
                n_num = 26'd10240 * {18'd0, i_blue} + 26'd51;
            end
            default: begin
                n_num = '0;
                n_den = 11'd1;
            end
        endcase
    end

    logic             r_vld [0:NSTG];
    logic             r_ok  [0:NSTG];
    logic [NUM_W-1:0] r_rem [0:NSTG];
    logic [DEN_W-1:0] r_den [0:NSTG];
    logic [KEY_W-1:0] r_q   [0:NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_start;
        end
        r_ok[0]  <= (i_alpha != 8'd0);
        r_rem[0] <= n_num;
        r_den[0] <= n_den;
        r_q[0]   <= '0;
    end

    for (genvar k = 0; k < NSTG; k++) begin : g_div
        localparam int unsigned SH = NSTG - 1 - k;
        logic [NUM_W-1:0] dsh;
        logic             take;
        assign dsh  = NUM_W'(r_den[k]) << SH;
        assign take = (r_rem[k] >= dsh);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_ok[k+1]  <= r_ok[k];
            r_den[k+1] <= r_den[k];
            r_rem[k+1] <= take ? (r_rem[k] - dsh) : r_rem[k];
            r_q[k+1]   <= {r_q[k][KEY_W-2:0], take};
        end
    end

    logic signed [16:0] key_s, lo_s, hi_s, res;
    logic               excl;

    always_comb begin
        key_s = {2'b00, r_q[NSTG]};
        lo_s  = {2'b00, r_lo};
        hi_s  = {2'b00, r_hi};
        excl  = 1'b0;
        res   = key_s - lo_s;
        if (!r_ok[NSTG] || r_lo == r_hi) begin
            excl = 1'b1;
        end else if (r_lo < r_hi) begin
            if (key_s > hi_s) excl = 1'b1;
        end else if (key_s < hi_s) begin
            res = key_s + 17'sd25600 - lo_s;
        end
    end

    logic               r_done;
    logic signed [15:0] r_key;
    logic               r_excl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[NSTG];
        end
        r_key  <= excl ? EXCLUDED_KEY : res[15:0];
        r_excl <= excl;
    end

    assign o_done     = r_done;
    assign o_sort_key = r_key;
    assign o_excluded = r_excl;

endmodule
